// File: src/kpt_pkg.sv
`default_nettype none
package kpt_pkg;

	localparam int NUM_W     = 26;
	localparam int FREQ_W    = 16;
	localparam int DIVISOR_W = FREQ_W + 1;
	localparam int DIV_STEPS = NUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int BCD_DIGITS = 5;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int BCD_CNT_W  = $clog2(FREQ_W);

	localparam logic [NUM_W-1:0]  NUMERATOR_RST = 26'd33177600;
	localparam logic [FREQ_W-1:0] BASE_RST      = 16'd3100;
	localparam logic [FREQ_W-1:0] FREQ_RST      = 16'd400;
	localparam logic [FREQ_W-1:0] HALF_RST      = 16'd41472;
	localparam logic [FREQ_W-1:0] BASE_STEP     = 16'd5;

	localparam logic [7:0] KEY_NOTE_1 = 8'h7e;
	localparam logic [7:0] KEY_NOTE_2 = 8'h7d;
	localparam logic [7:0] KEY_NOTE_3 = 8'h7b;
	localparam logic [7:0] KEY_NOTE_4 = 8'hbe;
	localparam logic [7:0] KEY_NOTE_5 = 8'hbd;
	localparam logic [7:0] KEY_NOTE_6 = 8'hbb;
	localparam logic [7:0] KEY_NOTE_7 = 8'hde;
	localparam logic [7:0] KEY_NOTE_8 = 8'hdd;
	localparam logic [7:0] KEY_NOTE_9 = 8'hdb;
	localparam logic [7:0] KEY_UP     = 8'h77;
	localparam logic [7:0] KEY_DOWN   = 8'hd7;

	typedef struct packed {
		logic              hit;
		logic [FREQ_W-1:0] step;
	} note_t;

	typedef struct packed {
		logic [7:0] ten_thousands;
		logic [7:0] thousands;
		logic [7:0] hundreds;
		logic [7:0] tens;
		logic [7:0] units;
	} seg_set_t;

	function automatic note_t note_decode(input logic [7:0] code);
		note_t n;
		n.hit = 1'b1;
		unique case (code)
			KEY_NOTE_1: n.step = 16'd400;
			KEY_NOTE_2: n.step = 16'd800;
			KEY_NOTE_3: n.step = 16'd1200;
			KEY_NOTE_4: n.step = 16'd1600;
			KEY_NOTE_5: n.step = 16'd2000;
			KEY_NOTE_6: n.step = 16'd2400;
			KEY_NOTE_7: n.step = 16'd2800;
			KEY_NOTE_8: n.step = 16'd3200;
			KEY_NOTE_9: n.step = 16'd3600;
			default: begin
				n.hit  = 1'b0;
				n.step = '0;
			end
		endcase
		return n;
	endfunction

	// active-low seven segment codes, decimal point off
	function automatic logic [7:0] seg_code(input logic [3:0] digit);
		logic [7:0] s;
		unique case (digit)
			4'd0: s = 8'hc0;
			4'd1: s = 8'hf9;
			4'd2: s = 8'ha4;
			4'd3: s = 8'hb0;
			4'd4: s = 8'h99;
			4'd5: s = 8'h92;
			4'd6: s = 8'h82;
			4'd7: s = 8'hf8;
			4'd8: s = 8'h80;
			4'd9: s = 8'h90;
			default: s = 8'hff;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// File: src/kpt_div.sv
`default_nettype none
module kpt_div
	import kpt_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [NUM_W-1:0]     numerator,
	input  wire logic [DIVISOR_W-1:0] divisor,
	output logic                      busy,
	output logic [FREQ_W-1:0]         quotient
);

	logic [NUM_W-1:0]     num_q;
	logic [DIVISOR_W-1:0] div_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [FREQ_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;

	logic [DIVISOR_W:0]   trial;
	logic [DIVISOR_W:0]   diff;
	logic                 fits;

	// one quotient bit per cycle, restoring form
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numerator;
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			// upper quotient bits fall off, only the low 16 bits are kept
			quo_q <= {quo_q[FREQ_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// File: src/kpt_bcd.sv
`default_nettype none
module kpt_bcd
	import kpt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [FREQ_W-1:0] value,
	output logic                   busy,
	output seg_set_t               segs
);

	logic [FREQ_W-1:0]    bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [BCD_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	seg_set_t             segs_q;

	logic [BCD_W-1:0]     adj;
	logic [BCD_W-1:0]     bcd_next;

	// shift-add-3, one binary bit per cycle
	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ?
				bcd_q[4*i +: 4] + 4'd3 : bcd_q[4*i +: 4];
		end
		bcd_next = {adj[BCD_W-2:0], bin_q[FREQ_W-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q               <= 1'b0;
			cnt_q                <= '0;
			segs_q.ten_thousands <= seg_code(4'd0);
			segs_q.thousands     <= seg_code(4'd0);
			segs_q.hundreds      <= seg_code(4'd4);
			segs_q.tens          <= seg_code(4'd0);
			segs_q.units         <= seg_code(4'd0);
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == BCD_CNT_W'(FREQ_W - 1)) begin
				busy_q               <= 1'b0;
				segs_q.ten_thousands <= seg_code(bcd_next[19:16]);
				segs_q.thousands     <= seg_code(bcd_next[15:12]);
				segs_q.hundreds      <= seg_code(bcd_next[11:8]);
				segs_q.tens          <= seg_code(bcd_next[7:4]);
				segs_q.units         <= seg_code(bcd_next[3:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[FREQ_W-2:0], 1'b0};
			bcd_q <= bcd_next;
		end
	end

	assign busy = busy_q;
	assign segs = segs_q;

endmodule
`default_nettype wire

// File: src/keypad_tone_generator_core.sv
// order: a timer tick goes from the input straight to the hold state and then into the
// output register; a key press that starts a tone first waits in the wait state until
// the bit-serial divider and the decimal converter, which run side by side, are done
// throughput: one item at a time; a new input is taken once the previous result
// sits in the output register
// reset: asynchronous, tone of 400 running, buzzer pin high, counters cleared
`default_nettype none
module keypad_tone_generator_core
	import kpt_pkg::*;
#(
	parameter int STOP_OVERFLOWS = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [NUM_W-1:0]  cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              action,
	input  wire logic [7:0]        key_code,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   buzzer_level,
	output logic                   tone_active,
	output logic [FREQ_W-1:0]      frequency_word,
	output logic [7:0]             seg_units,
	output logic [7:0]             seg_tens,
	output logic [7:0]             seg_hundreds,
	output logic [7:0]             seg_thousands,
	output logic [7:0]             seg_ten_thousands
);

	localparam logic [3:0] STOP_LIM = 4'(STOP_OVERFLOWS);

	typedef enum logic [1:0] {ST_IDLE, ST_START, ST_WAIT, ST_HOLD} state_t;

	state_t            state_q;
	logic [NUM_W-1:0]  numerator_q;
	logic [FREQ_W-1:0] base_q;
	logic [FREQ_W-1:0] freq_q;
	logic [FREQ_W-1:0] half_q;
	logic [FREQ_W-1:0] tone_cnt_q;
	logic              running_q;
	logic              pin_q;
	logic [FREQ_W-1:0] dur_q;
	logic [3:0]        ovf_q;

	logic              out_valid_q;
	logic              buzzer_q;
	logic              active_q;
	logic [FREQ_W-1:0] freq_out_q;
	seg_set_t          segs_out_q;

	logic              in_xfer;
	logic              out_free;
	logic              freq_zero;
	logic              div_start;
	logic              bcd_start;
	logic              div_busy;
	logic              bcd_busy;
	logic [FREQ_W-1:0] quotient;
	seg_set_t          segs;
	note_t             note;
	logic [FREQ_W-1:0] dur_inc;
	logic [3:0]        ovf_inc;
	logic              tick_stop;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign freq_zero = (freq_q == '0);
	assign div_start = (state_q == ST_START) && !freq_zero;
	assign bcd_start = (state_q == ST_START);
	assign note      = note_decode(key_code);
	assign dur_inc   = dur_q + 1'b1;
	assign ovf_inc   = ovf_q + 1'b1;
	assign tick_stop = (dur_inc == '0) && (ovf_inc >= STOP_LIM);

	kpt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.numerator (numerator_q),
		.divisor   ({freq_q, 1'b0}),
		.busy      (div_busy),
		.quotient  (quotient)
	);

	kpt_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start),
		.value  (freq_q),
		.busy   (bcd_busy),
		.segs   (segs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numerator_q <= NUMERATOR_RST;
		end else if (cfg_wr_en) begin
			numerator_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= BASE_RST;
			freq_q      <= FREQ_RST;
			half_q      <= HALF_RST;
			tone_cnt_q  <= '0;
			running_q   <= 1'b1;
			pin_q       <= 1'b1;
			dur_q       <= '0;
			ovf_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_HOLD && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (action) begin
							state_q <= ST_HOLD;
							if (running_q) begin
								if (tone_cnt_q == half_q - 1'b1) begin
									tone_cnt_q <= '0;
									// stop beats a toggle on the same tick
									if (!tick_stop)
										pin_q <= ~pin_q;
								end else begin
									tone_cnt_q <= tone_cnt_q + 1'b1;
								end
								dur_q <= dur_inc;
								if (tick_stop) begin
									ovf_q     <= '0;
									running_q <= 1'b0;
									pin_q     <= 1'b1;
								end else if (dur_inc == '0) begin
									ovf_q <= ovf_inc;
								end
							end
						end else begin
							priority if (note.hit) begin
								freq_q  <= base_q + note.step;
								state_q <= ST_START;
							end else if (key_code == KEY_UP) begin
								base_q  <= base_q + BASE_STEP;
								state_q <= ST_START;
							end else if (key_code == KEY_DOWN) begin
								base_q  <= base_q - BASE_STEP;
								state_q <= ST_START;
							end else begin
								state_q <= ST_HOLD;
							end
						end
					end
				end
				ST_START: begin
					// zero divisor silences the tone, half period kept
					if (freq_zero) begin
						running_q <= 1'b0;
						pin_q     <= 1'b1;
					end
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!div_busy && !bcd_busy) begin
						if (!freq_zero) begin
							half_q     <= quotient;
							tone_cnt_q <= '0;
							running_q  <= 1'b1;
						end
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			buzzer_q   <= pin_q;
			active_q   <= running_q;
			freq_out_q <= freq_q;
			segs_out_q <= segs;
		end
	end

	assign out_valid         = out_valid_q;
	assign buzzer_level      = buzzer_q;
	assign tone_active       = active_q;
	assign frequency_word    = freq_out_q;
	assign seg_units         = segs_out_q.units;
	assign seg_tens          = segs_out_q.tens;
	assign seg_hundreds      = segs_out_q.hundreds;
	assign seg_thousands     = segs_out_q.thousands;
	assign seg_ten_thousands = segs_out_q.ten_thousands;

endmodule
`default_nettype wire

// File: dv/keypad_tone_generator_core_test.sv
`timescale 1ns / 100ps

module keypad_tone_generator_core_test
	import kpt_pkg::*;
;

	localparam int STOP_COUNT = 10;
	localparam int IDLE_LIMIT = 5000;
	localparam logic ACT_KEY  = 1'b0;
	localparam logic ACT_TICK = 1'b1;
	localparam logic [0:9][7:0] SEG_LUT = {
		8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
	};
	localparam logic [0:8][7:0] NOTE_KEYS = {
		KEY_NOTE_1, KEY_NOTE_2, KEY_NOTE_3, KEY_NOTE_4, KEY_NOTE_5,
		KEY_NOTE_6, KEY_NOTE_7, KEY_NOTE_8, KEY_NOTE_9
	};

	typedef struct packed {
		logic       act;
		logic [7:0] code;
	} pad_event_t;

	typedef struct packed {
		logic              buzz;
		logic              active;
		logic [FREQ_W-1:0] freq;
		logic [7:0]        seg_u;
		logic [7:0]        seg_t;
		logic [7:0]        seg_h;
		logic [7:0]        seg_th;
		logic [7:0]        seg_tt;
	} tone_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [NUM_W-1:0]  cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              action = ACT_KEY;
	logic [7:0]        key_code = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              buzzer_level;
	logic              tone_active;
	logic [FREQ_W-1:0] frequency_word;
	logic [7:0]        seg_units;
	logic [7:0]        seg_tens;
	logic [7:0]        seg_hundreds;
	logic [7:0]        seg_thousands;
	logic [7:0]        seg_ten_thousands;

	// tone state as the block should hold it
	logic [NUM_W-1:0]  numerator = NUMERATOR_RST;
	logic [FREQ_W-1:0] base_hz = 16'd3100;
	logic [FREQ_W-1:0] freq_hz = 16'd400;
	logic [FREQ_W-1:0] half_ticks = 16'd41472;
	logic [FREQ_W-1:0] phase_cnt = '0;
	logic              sounding = 1'b1;
	logic              pin = 1'b1;
	logic [15:0]       dur_cnt = '0;
	logic [3:0]        ovf_cnt = '0;

	pad_event_t   pad_events[$];
	tone_result_t expected_outputs[$];

	int  mismatches = 0;
	int  result_count = 0;
	int  key_count = 0;
	int  tick_count = 0;
	int  toggle_count = 0;
	int  stop_count = 0;
	int  silent_starts = 0;
	int  config_writes = 0;
	int  hold_off = 0;
	int  stall_left = 0;
	int  stretch_left = 0;
	int  idle_cycles = 0;
	logic quiet_stretch = 1'b0;
	wire  calm = quiet_stretch;

	keypad_tone_generator_core #(
		.STOP_OVERFLOWS(STOP_COUNT)
	) uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_wr_en         (cfg_wr_en),
		.cfg_wr_data       (cfg_wr_data),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.action            (action),
		.key_code          (key_code),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.buzzer_level      (buzzer_level),
		.tone_active       (tone_active),
		.frequency_word    (frequency_word),
		.seg_units         (seg_units),
		.seg_tens          (seg_tens),
		.seg_hundreds      (seg_hundreds),
		.seg_thousands     (seg_thousands),
		.seg_ten_thousands (seg_ten_thousands)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 3);
		else if (r < 90)
			return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	task automatic start_tone();
		logic [NUM_W-1:0] quotient;
		if (freq_hz == '0) begin
			// divisor of zero: tone goes silent, half period kept
			sounding = 1'b0;
			pin = 1'b1;
			silent_starts++;
		end else begin
			quotient = numerator / {9'd0, freq_hz, 1'b0};
			half_ticks = quotient[FREQ_W-1:0];
			phase_cnt = '0;
			sounding = 1'b1;
		end
	endtask

	task automatic apply_event(input pad_event_t ev, output tone_result_t r);
		logic [FREQ_W-1:0] step;
		int f;
		if (ev.act == ACT_TICK) begin
			tick_count++;
			if (sounding) begin
				if (phase_cnt == half_ticks - 16'd1) begin
					phase_cnt = '0;
					pin = ~pin;
					toggle_count++;
				end else begin
					phase_cnt = phase_cnt + 16'd1;
				end
				dur_cnt = dur_cnt + 16'd1;
				if (dur_cnt == '0) begin
					ovf_cnt = ovf_cnt + 4'd1;
					// stop beats a toggle on the same tick
					if (ovf_cnt >= 4'(STOP_COUNT)) begin
						ovf_cnt = '0;
						sounding = 1'b0;
						pin = 1'b1;
						stop_count++;
					end
				end
			end
		end else begin
			key_count++;
			step = '0;
			case (ev.code)
				KEY_NOTE_1: step = 16'd400;
				KEY_NOTE_2: step = 16'd800;
				KEY_NOTE_3: step = 16'd1200;
				KEY_NOTE_4: step = 16'd1600;
				KEY_NOTE_5: step = 16'd2000;
				KEY_NOTE_6: step = 16'd2400;
				KEY_NOTE_7: step = 16'd2800;
				KEY_NOTE_8: step = 16'd3200;
				KEY_NOTE_9: step = 16'd3600;
				KEY_UP:     base_hz = base_hz + 16'd5;
				KEY_DOWN:   base_hz = base_hz - 16'd5;
				default: ;
			endcase
			if (step != '0)
				freq_hz = base_hz + step;
			if (step != '0 || ev.code == KEY_UP || ev.code == KEY_DOWN)
				start_tone();
		end
		f = int'(freq_hz);
		r.buzz   = pin;
		r.active = sounding;
		r.freq   = freq_hz;
		r.seg_u  = SEG_LUT[4'(f % 10)];
		r.seg_t  = SEG_LUT[4'((f / 10) % 10)];
		r.seg_h  = SEG_LUT[4'((f / 100) % 10)];
		r.seg_th = SEG_LUT[4'((f / 1000) % 10)];
		r.seg_tt = SEG_LUT[4'((f / 10000) % 10)];
	endtask

	task automatic check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 40)
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, what, want, got);
		end
	endtask

	// input side: one pending event on the bus at a time
	always @(posedge clk or negedge arst_n) begin : drive_events
		pad_event_t ev;
		tone_result_t res;
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_KEY;
			key_code <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				ev.act = action;
				ev.code = key_code;
				apply_event(ev, res);
				expected_outputs.push_back(res);
			end
			if (!in_valid || !in_stall) begin
				if (hold_off > 0) begin
					hold_off--;
					in_valid <= 1'b0;
				end else if (pad_events.size() != 0) begin
					ev = pad_events.pop_front();
					in_valid <= 1'b1;
					action <= ev.act;
					key_code <= ev.code;
					if (calm || $urandom_range(0, 9) < 4)
						hold_off = 0;
					else
						hold_off = gap_length();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side: check each transfer, stall at random
	always @(posedge clk or negedge arst_n) begin : watch_outputs
		tone_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				result_count++;
				if (expected_outputs.size() == 0) begin
					mismatches++;
					if (mismatches <= 40)
						$display("%0t: result with nothing expected, frequency_word %0d",
							$time, frequency_word);
				end else begin
					want = expected_outputs.pop_front();
					check_field("buzzer_level", 16'(want.buzz), 16'(buzzer_level));
					check_field("tone_active", 16'(want.active), 16'(tone_active));
					check_field("frequency_word", want.freq, frequency_word);
					check_field("seg_units", 16'(want.seg_u), 16'(seg_units));
					check_field("seg_tens", 16'(want.seg_t), 16'(seg_tens));
					check_field("seg_hundreds", 16'(want.seg_h), 16'(seg_hundreds));
					check_field("seg_thousands", 16'(want.seg_th), 16'(seg_thousands));
					check_field("seg_ten_thousands", 16'(want.seg_tt),
						16'(seg_ten_thousands));
				end
			end
			if (stall_left > 0 && !calm) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				stall_left = 0;
				if (!calm && $urandom_range(0, 3) == 0)
					stall_left = gap_length();
			end
			// alternate busy stretches with stretches free of gaps
			if (stretch_left > 0) begin
				stretch_left--;
			end else begin
				stretch_left = $urandom_range(50, 400);
				quiet_stretch <= ($urandom_range(0, 3) == 0);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				$time, idle_cycles, expected_outputs.size());
			$display("simulation failed");
			$finish;
		end
	end

	task automatic queue_event(input logic act, input logic [7:0] code);
		pad_event_t ev;
		ev.act = act;
		ev.code = code;
		pad_events.push_back(ev);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pad_events.size() != 0 || in_valid || expected_outputs.size() != 0);
	endtask

	task automatic write_numerator(input logic [NUM_W-1:0] value);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		numerator = value;
		config_writes++;
	endtask

	initial begin : stimulus
		int pick;
		int downs;
		logic [FREQ_W-1:0] probe;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values, unknown codes, every key
		queue_event(ACT_TICK, 8'hff);
		queue_event(ACT_KEY, 8'h00);
		queue_event(ACT_KEY, 8'hff);
		for (int k = 0; k < 9; k++)
			queue_event(ACT_KEY, NOTE_KEYS[4'(k)]);
		queue_event(ACT_KEY, KEY_UP);
		queue_event(ACT_KEY, KEY_DOWN);
		queue_event(ACT_TICK, 8'h00);

		// smallest numerator: half period truncates to zero
		write_numerator(26'd1);
		queue_event(ACT_KEY, KEY_NOTE_9);
		queue_event(ACT_TICK, 8'h5a);
		queue_event(ACT_TICK, 8'ha5);

		write_numerator({NUM_W{1'b1}});
		queue_event(ACT_KEY, KEY_NOTE_1);
		queue_event(ACT_KEY, KEY_UP);
		queue_event(ACT_TICK, 8'h3c);

		// walk the base offset down until a note lands on frequency zero
		wait_drained();
		probe = base_hz;
		downs = 0;
		while (probe + 16'd400 != 16'd0 && downs < 4000) begin
			probe = probe - 16'd5;
			downs++;
		end
		repeat (downs) begin
			if ($urandom_range(0, 9) == 0)
				queue_event(ACT_TICK, 8'($urandom));
			queue_event(ACT_KEY, KEY_DOWN);
		end
		queue_event(ACT_KEY, KEY_NOTE_1);
		repeat (3) queue_event(ACT_TICK, 8'($urandom));
		queue_event(ACT_KEY, KEY_UP);
		queue_event(ACT_TICK, 8'($urandom));
		queue_event(ACT_KEY, KEY_DOWN);
		queue_event(ACT_KEY, KEY_NOTE_2);

		for (int s = 0; s < 4; s++) begin
			case (s)
				0: write_numerator(NUMERATOR_RST);
				1: write_numerator(NUM_W'($urandom_range(1, 40000)));
				2: write_numerator(NUM_W'($urandom_range(1, 2 ** NUM_W - 1)));
				default: write_numerator(NUM_W'($urandom_range(2, 4000)));
			endcase
			repeat (190) begin
				pick = $urandom_range(0, 99);
				if (pick < 62)
					queue_event(ACT_TICK, 8'($urandom));
				else if (pick < 82)
					queue_event(ACT_KEY, NOTE_KEYS[4'($urandom_range(0, 8))]);
				else if (pick < 90)
					queue_event(ACT_KEY, $urandom_range(0, 1) ? KEY_UP : KEY_DOWN);
				else
					queue_event(ACT_KEY, 8'($urandom_range(0, 255)));
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		$display("covered %0d key presses and %0d ticks under %0d numerator settings",
			key_count, tick_count, config_writes);
		$display("%0d results checked: %0d toggles, %0d tone stops, %0d silent starts",
			result_count, toggle_count, stop_count, silent_starts);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
